[sv/softened_pair_gravity_accel_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the softened pair gravity block
// Concurrent assertion wrappers with a common clock and reset form.
// ----------------------------------------------------------------------------
`ifndef SOFTENED_PAIR_GRAVITY_ACCEL_ASSERT_SVH
`define SOFTENED_PAIR_GRAVITY_ACCEL_ASSERT_SVH

// Implication check: antecedent and consequent written as one property.
`define SPGA_ASSERT_IMPL(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Invariant check on a single boolean expression.
`define SPGA_ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
  `SPGA_ASSERT_IMPL(lbl, clk, rstn, (expr), msg)

`endif

[sv/spga_pkg.sv]
// ----------------------------------------------------------------------------
// spga_pkg
// Shared widths, register indexes, reset values and the output clip function.
// ----------------------------------------------------------------------------
`default_nettype none

package spga_pkg;

  localparam int unsigned UW       = 33;   // |difference| of two 32-bit values
  localparam int unsigned SQ_W     = 66;   // sums of squares
  localparam int unsigned ROOT_W   = 33;   // floor root of SQ_W bits
  localparam int unsigned GM_W     = 64;   // G * mass
  localparam int unsigned DEN_W    = 99;   // D * r
  localparam int unsigned PROD_W   = 97;   // G * mass * u
  localparam int unsigned Q_W      = 32;   // quotient bits resolved
  localparam int unsigned DIV_W    = DEN_W + Q_W;
  localparam int unsigned SQRT_STG = ROOT_W;
  localparam int unsigned DIV_STG  = Q_W + 1;

  localparam logic [31:0] GRAVITY_RST   = 32'd65536;
  localparam logic [31:0] SOFTENING_RST = 32'd19661;

  typedef enum logic [0:0] {
    REG_GRAVITY   = 1'b0,
    REG_SOFTENING = 1'b1
  } reg_idx_e;

  // Item state carried alongside the square root.
  typedef struct packed {
    logic              id_eq;
    logic              dy_zero;
    logic              ax_neg;
    logic              ay_neg;
    logic [SQ_W-1:0]   dsq;
    logic [GM_W-1:0]   gm_a;
    logic [GM_W-1:0]   gm_b;
    logic [UW-1:0]     uxd;
    logic [UW-1:0]     uy;
  } info_t;

  // Item flags carried alongside the dividers.
  typedef struct packed {
    logic id_eq;
    logic dy_zero;
    logic ax_neg;
    logic ay_neg;
  } flags_t;

  // Apply sign to a magnitude, clipping to the signed 32-bit range.
  // Returns {clipped, value}.
  function automatic logic [32:0] clip_part(input logic [Q_W-1:0] q,
                                            input logic ovf, input logic neg);
    logic [31:0] limit;
    logic [31:0] mag;
    logic        sat;
    limit = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    sat   = ovf || (q > limit);
    mag   = sat ? limit : q;
    return {sat, neg ? (32'd0 - mag) : mag};
  endfunction

endpackage

`default_nettype wire

[sv/spga_isqrt.sv]
// ----------------------------------------------------------------------------
// spga_isqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module spga_isqrt (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic [spga_pkg::SQ_W-1:0]  rad_i,
  output logic      [spga_pkg::ROOT_W-1:0] root_o
);

  localparam int unsigned N     = spga_pkg::SQRT_STG;
  localparam int unsigned RW    = spga_pkg::ROOT_W;
  localparam int unsigned SW    = spga_pkg::SQ_W;
  localparam int unsigned REM_W = RW + 3;

  logic [SW-1:0]    rad_q  [0:N-1];
  logic [REM_W-1:0] rem_q  [0:N-1];
  logic [RW-1:0]    root_q [0:N-1];

  for (genvar k = 0; k < N; k++) begin : g_stg
    logic [SW-1:0]    rad_in;
    logic [REM_W-1:0] rem_in;
    logic [RW-1:0]    root_in;
    logic [REM_W-1:0] cand;
    logic [REM_W-1:0] trial;

    if (k == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // bring down two radicand bits, try (root*4 + 1)
    assign cand  = {rem_in[REM_W-3:0], rad_in[SW-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k] <= {rad_in[SW-3:0], 2'b00};
        if (cand >= trial) begin
          rem_q[k]  <= cand - trial;
          root_q[k] <= {root_in[RW-2:0], 1'b1};
        end else begin
          rem_q[k]  <= cand;
          root_q[k] <= {root_in[RW-2:0], 1'b0};
        end
      end
    end
  end

  assign root_o = root_q[N-1];

endmodule

`default_nettype wire

[sv/spga_div.sv]
// ----------------------------------------------------------------------------
// spga_div
// Pipelined restoring divider: overflow check, then one quotient bit a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module spga_div (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic [spga_pkg::DIV_W-1:0] num_i,
  input  wire logic [spga_pkg::DEN_W-1:0] den_i,
  output logic      [spga_pkg::Q_W-1:0]   q_o,
  output logic                            ovf_o
);

  localparam int unsigned QW = spga_pkg::Q_W;
  localparam int unsigned DW = spga_pkg::DIV_W;
  localparam int unsigned NW = spga_pkg::DEN_W;

  logic [DW-1:0] rem_q [0:QW];
  logic [NW-1:0] den_q [0:QW];
  logic [QW-1:0] q_q   [0:QW];
  logic          ovf_q [0:QW];

  // quotient would not fit in QW bits
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i;
      den_q[0] <= den_i;
      q_q[0]   <= '0;
      ovf_q[0] <= num_i >= {den_i, {QW{1'b0}}};
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stg
    logic [DW-1:0] dsh;
    logic          take;
    assign dsh  = DW'(den_q[k]) << (QW - 1 - k);
    assign take = rem_q[k] >= dsh;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= take ? rem_q[k] - dsh : rem_q[k];
        den_q[k+1] <= den_q[k];
        q_q[k+1]   <= {q_q[k][QW-2:0], take};
        ovf_q[k+1] <= ovf_q[k];
      end
    end
  end

  assign q_o   = q_q[QW];
  assign ovf_o = ovf_q[QW];

endmodule

`default_nettype wire

[sv/softened_pair_gravity_accel.sv]
// ----------------------------------------------------------------------------
// softened_pair_gravity_accel
// Pairwise softened gravity: acceleration increments for two bodies.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one body pair a beat; m_axis returns one result beat per
//   pair, in order. cfg_we_i/cfg_idx_i/cfg_wdata_i write G (index 0) and the
//   softening length (index 1); write them only while no pair is in flight.
//   An accepted input beat reaches m_axis_tvalid through 3 setup stages,
//   a 33-stage square root, 2 wide-multiply stages, a 33-stage divider and
//   the output register. Throughput is one pair per cycle while the output
//   is not stalled; the four dividers and the root are fully pipelined.
//   The whole pipeline advances together whenever the output register is
//   empty or being taken, so s_axis_tready drops only while a result waits
//   on a stalled receiver; no beat is lost or repeated.
//   Reset clears all valid bits and loads G = 1.0 and softening = 0.3.
// ----------------------------------------------------------------------------
`default_nettype none

module softened_pair_gravity_accel #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // pos_x_a, pos_y_a, mass_a, id_a, pos_x_b, pos_y_b, mass_b, id_b
  input  wire logic [223:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // accel_x_a, accel_y_a, accel_x_b, accel_y_b
  output logic      [127:0] m_axis_tdata,
  // saturated
  output logic      [0:0]   m_axis_tuser,
  input  wire logic         cfg_we_i,
  input  wire logic [0:0]   cfg_idx_i,
  input  wire logic [31:0]  cfg_wdata_i
);

  localparam int unsigned UW   = spga_pkg::UW;
  localparam int unsigned SW   = spga_pkg::SQ_W;
  localparam int unsigned RW   = spga_pkg::ROOT_W;
  localparam int unsigned GW   = spga_pkg::GM_W;
  localparam int unsigned DNW  = spga_pkg::DEN_W;
  localparam int unsigned PW   = spga_pkg::PROD_W;
  localparam int unsigned DVW  = spga_pkg::DIV_W;
  localparam int unsigned QW   = spga_pkg::Q_W;
  localparam int unsigned NSQ  = spga_pkg::SQRT_STG;
  localparam int unsigned NDV  = spga_pkg::DIV_STG;
  localparam int unsigned NVLD = 3 + NSQ + 2 + NDV;
  localparam int unsigned SDX_CALC = ((1 << FRAC_BITS) + 500) / 1000;
  localparam logic [UW-1:0] SMALL_DX = (SDX_CALC > 0) ? UW'(SDX_CALC) : UW'(1);

  // configuration registers
  logic [31:0] grav_q, soft_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q <= spga_pkg::GRAVITY_RST;
      soft_q <= spga_pkg::SOFTENING_RST;
    end else if (cfg_we_i) begin
      unique case (spga_pkg::reg_idx_e'(cfg_idx_i))
        spga_pkg::REG_GRAVITY:   grav_q <= cfg_wdata_i;
        spga_pkg::REG_SOFTENING: soft_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // advance everything when the output slot is free or being taken
  logic en, in_fire;
  logic [NVLD-1:0] vld_q;
  logic            out_vld_q;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;
  assign in_fire       = s_axis_tvalid && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[NVLD-2:0], in_fire};
      out_vld_q <= vld_q[NVLD-1];
    end
  end

  // unpack input beat
  logic [31:0] px_a, py_a, m_a, px_b, py_b, m_b;
  logic [15:0] id_a, id_b;
  assign px_a = s_axis_tdata[31:0];
  assign py_a = s_axis_tdata[63:32];
  assign m_a  = s_axis_tdata[95:64];
  assign id_a = s_axis_tdata[111:96];
  assign px_b = s_axis_tdata[143:112];
  assign py_b = s_axis_tdata[175:144];
  assign m_b  = s_axis_tdata[207:176];
  assign id_b = s_axis_tdata[223:208];

  // stage 1: differences and magnitudes
  logic signed [UW-1:0] dx, dy;
  assign dx = $signed({px_b[31], px_b}) - $signed({px_a[31], px_a});
  assign dy = $signed({py_b[31], py_b}) - $signed({py_a[31], py_a});

  logic [UW-1:0] s1_ux_q, s1_uy_q, s1_uxd_q;
  logic [31:0]   s1_ma_q, s1_mb_q;
  spga_pkg::flags_t s1_fl_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_ux_q  <= dx[UW-1] ? UW'(-dx) : UW'(dx);
      s1_uy_q  <= dy[UW-1] ? UW'(-dy) : UW'(dy);
      s1_uxd_q <= (dx == '0) ? SMALL_DX : (dx[UW-1] ? UW'(-dx) : UW'(dx));
      s1_ma_q  <= m_a;
      s1_mb_q  <= m_b;
      s1_fl_q  <= '{id_eq: (id_a == id_b), dy_zero: (dy == '0),
                    ax_neg: dx[UW-1], ay_neg: dy[UW-1]};
    end
  end

  // stage 2: squares and G * mass
  logic [SW-1:0] s2_ux2_q, s2_uy2_q, s2_uxd2_q;
  logic [63:0]   s2_eps2_q;
  logic [GW-1:0] s2_gma_q, s2_gmb_q;
  logic [UW-1:0] s2_uxd_q, s2_uy_q;
  spga_pkg::flags_t s2_fl_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_ux2_q  <= s1_ux_q * s1_ux_q;
      s2_uy2_q  <= s1_uy_q * s1_uy_q;
      s2_uxd2_q <= s1_uxd_q * s1_uxd_q;
      s2_eps2_q <= soft_q * soft_q;
      s2_gma_q  <= grav_q * s1_ma_q;
      s2_gmb_q  <= grav_q * s1_mb_q;
      s2_uxd_q  <= s1_uxd_q;
      s2_uy_q   <= s1_uy_q;
      s2_fl_q   <= s1_fl_q;
    end
  end

  // stage 3: softened distance squared and the root radicand
  logic [SW-1:0] dsq_sum;
  logic [SW-1:0] s3_rad_q;
  spga_pkg::info_t s3_info_q;
  assign dsq_sum = s2_ux2_q + s2_uy2_q + SW'(s2_eps2_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_rad_q <= s2_uxd2_q + s2_uy2_q;
      s3_info_q.id_eq   <= s2_fl_q.id_eq;
      s3_info_q.dy_zero <= s2_fl_q.dy_zero;
      s3_info_q.ax_neg  <= s2_fl_q.ax_neg;
      s3_info_q.ay_neg  <= s2_fl_q.ay_neg;
      // coincident bodies with no softening: hold D at one step
      s3_info_q.dsq     <= (dsq_sum == '0) ? SW'(1) : dsq_sum;
      s3_info_q.gm_a    <= s2_gma_q;
      s3_info_q.gm_b    <= s2_gmb_q;
      s3_info_q.uxd     <= s2_uxd_q;
      s3_info_q.uy      <= s2_uy_q;
    end
  end

  // square root, item state travels beside it
  logic [RW-1:0] root;
  spga_pkg::info_t info_q [0:NSQ-1];

  spga_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (s3_rad_q),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      info_q[0] <= s3_info_q;
      for (int i = 1; i < NSQ; i++) info_q[i] <= info_q[i-1];
    end
  end

  spga_pkg::info_t inf;
  assign inf = info_q[NSQ-1];

  // multiply stage: partial products, upper and lower halves
  logic [65:0] m_dlo_q, m_dhi_q;
  logic [64:0] m_pax_lo_q, m_pax_hi_q, m_pay_lo_q, m_pay_hi_q;
  logic [64:0] m_pbx_lo_q, m_pbx_hi_q, m_pby_lo_q, m_pby_hi_q;
  spga_pkg::flags_t m_fl_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_dlo_q    <= inf.dsq[32:0] * root;
      m_dhi_q    <= inf.dsq[65:33] * root;
      // A is pulled by B's mass and vice versa
      m_pax_lo_q <= inf.gm_b[31:0] * inf.uxd;
      m_pax_hi_q <= inf.gm_b[63:32] * inf.uxd;
      m_pay_lo_q <= inf.gm_b[31:0] * inf.uy;
      m_pay_hi_q <= inf.gm_b[63:32] * inf.uy;
      m_pbx_lo_q <= inf.gm_a[31:0] * inf.uxd;
      m_pbx_hi_q <= inf.gm_a[63:32] * inf.uxd;
      m_pby_lo_q <= inf.gm_a[31:0] * inf.uy;
      m_pby_hi_q <= inf.gm_a[63:32] * inf.uy;
      m_fl_q     <= '{id_eq: inf.id_eq, dy_zero: inf.dy_zero,
                      ax_neg: inf.ax_neg, ay_neg: inf.ay_neg};
    end
  end

  // add stage: recombine, scale numerators by 2^FRAC_BITS
  logic [DNW-1:0] a_den_q;
  logic [DVW-1:0] a_num_q [0:3];
  spga_pkg::flags_t a_fl_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_den_q    <= DNW'(m_dlo_q) + {m_dhi_q, 33'd0};
      a_num_q[0] <= DVW'(PW'(m_pax_lo_q) + {m_pax_hi_q, 32'd0}) << FRAC_BITS;
      a_num_q[1] <= DVW'(PW'(m_pay_lo_q) + {m_pay_hi_q, 32'd0}) << FRAC_BITS;
      a_num_q[2] <= DVW'(PW'(m_pbx_lo_q) + {m_pbx_hi_q, 32'd0}) << FRAC_BITS;
      a_num_q[3] <= DVW'(PW'(m_pby_lo_q) + {m_pby_hi_q, 32'd0}) << FRAC_BITS;
      a_fl_q     <= m_fl_q;
    end
  end

  // four dividers share the denominator
  logic [QW-1:0] quo [0:3];
  logic          ovf [0:3];

  for (genvar g = 0; g < 4; g++) begin : g_div
    spga_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (a_num_q[g]),
      .den_i (a_den_q),
      .q_o   (quo[g]),
      .ovf_o (ovf[g])
    );
  end

  spga_pkg::flags_t dfl_q [0:NDV-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dfl_q[0] <= a_fl_q;
      for (int i = 1; i < NDV; i++) dfl_q[i] <= dfl_q[i-1];
    end
  end

  // output stage: sign, clip, special cases
  spga_pkg::flags_t fo;
  logic [32:0] c_xa, c_ya, c_xb, c_yb;
  assign fo   = dfl_q[NDV-1];
  assign c_xa = spga_pkg::clip_part(quo[0], ovf[0], fo.ax_neg);
  assign c_ya = spga_pkg::clip_part(quo[1], ovf[1], fo.ay_neg);
  assign c_xb = spga_pkg::clip_part(quo[2], ovf[2], !fo.ax_neg);
  assign c_yb = spga_pkg::clip_part(quo[3], ovf[3], !fo.ay_neg);

  logic [127:0] out_data_q;
  logic         out_sat_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (fo.id_eq) begin
        out_data_q <= '0;
        out_sat_q  <= 1'b0;
      end else if (fo.dy_zero) begin
        out_data_q <= {32'd0, c_xb[31:0], 32'd0, c_xa[31:0]};
        out_sat_q  <= c_xa[32] | c_xb[32];
      end else begin
        out_data_q <= {c_yb[31:0], c_xb[31:0], c_ya[31:0], c_xa[31:0]};
        out_sat_q  <= c_xa[32] | c_ya[32] | c_xb[32] | c_yb[32];
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_sat_q;

endmodule

`default_nettype wire

[sv/spga_chk.sv]
// ----------------------------------------------------------------------------
// spga_chk
// Port-level checks for the softened pair gravity block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "softened_pair_gravity_accel_assert.svh"

module spga_chk (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [127:0] m_axis_tdata,
  input wire logic [0:0]   m_axis_tuser
);

  logic at_limit;
  assign at_limit = m_axis_tdata[31:0] == 32'h7FFF_FFFF
                 || m_axis_tdata[31:0] == 32'h8000_0000
                 || m_axis_tdata[63:32] == 32'h7FFF_FFFF
                 || m_axis_tdata[63:32] == 32'h8000_0000
                 || m_axis_tdata[95:64] == 32'h7FFF_FFFF
                 || m_axis_tdata[95:64] == 32'h8000_0000
                 || m_axis_tdata[127:96] == 32'h7FFF_FFFF
                 || m_axis_tdata[127:96] == 32'h8000_0000;

  // a waiting result holds its beat
  `SPGA_ASSERT_IMPL(a_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)), "stalled result changed")

  // the pipeline only backs up behind a stalled result
  `SPGA_ASSERT_ALWAYS(a_ready, clk_i, rst_ni, (s_axis_tready || (m_axis_tvalid && !m_axis_tready)), "input stalled with output free")

  // a clipped beat shows at least one part at a range limit
  `SPGA_ASSERT_IMPL(a_sat, clk_i, rst_ni, (m_axis_tvalid && m_axis_tuser[0] |-> at_limit), "saturated flag without clipped part")

endmodule

bind softened_pair_gravity_accel spga_chk u_spga_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

[tb/softened_pair_gravity_accel_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// softened_pair_gravity_accel_checker
// Watches both streams, predicts each pair's accelerations and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module softened_pair_gravity_accel_checker (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  input  wire logic         s_axis_tready,
  input  wire logic [223:0] s_axis_tdata,
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic [127:0] m_axis_tdata,
  input  wire logic [0:0]   m_axis_tuser,
  input  wire logic         cfg_we_i,
  input  wire logic [0:0]   cfg_idx_i,
  input  wire logic [31:0]  cfg_wdata_i,
  output int                fail_count_o,
  output int                pending_o
);

  localparam int FRAC = 16;
  localparam logic [32:0] NUDGE_DX = 33'(((64'd1 << FRAC) + 64'd500) / 64'd1000);

  typedef struct {
    logic [127:0] accel;
    logic         sat;
  } accel_t;

  logic [31:0] grav_q;
  logic [31:0] soft_q;
  accel_t      accel_fifo[$];

  // floor square root of a value below 2^68
  function automatic logic [34:0] floor_root(input logic [67:0] s);
    logic [34:0] r;
    logic [34:0] c;
    r = '0;
    for (int b = 34; b >= 0; b--) begin
      c = r | (35'd1 << b);
      if ({2'b0, c} * {2'b0, c} <= {2'b0, s}) r = c;
    end
    return r;
  endfunction

  // signed, clipped part: sign * floor(num/den)
  function automatic logic [31:0] clip_quot(input logic [255:0] num, input logic [255:0] den,
                                            input logic neg, inout logic sat);
    logic [255:0] q;
    logic [255:0] lim;
    q   = num / den;
    lim = neg ? 256'h8000_0000 : 256'h7FFF_FFFF;
    if (q > lim) begin
      q   = lim;
      sat = 1'b1;
    end
    return neg ? 32'd0 - q[31:0] : q[31:0];
  endfunction

  // Field layout, lowest first: pos_x_a, pos_y_a, mass_a, id_a, pos_x_b, pos_y_b, mass_b, id_b
  function automatic accel_t predict_pair(input logic [223:0] d);
    accel_t       res;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic [32:0]  ux, uy, uxd;
    logic [255:0] d2, den, na, nb;
    logic [34:0]  r;
    logic         sat;
    logic [31:0]  ax, ay, bx, by;
    res.accel = '0;
    res.sat   = 1'b0;
    if (d[111:96] == d[223:208]) return res;
    dx  = $signed({{2{d[143]}}, d[143:112]}) - $signed({{2{d[31]}}, d[31:0]});
    dy  = $signed({{2{d[175]}}, d[175:144]}) - $signed({{2{d[63]}}, d[63:32]});
    ux  = dx < 0 ? 33'(-dx) : 33'(dx);
    uy  = dy < 0 ? 33'(-dy) : 33'(dy);
    d2  = 256'(ux) * 256'(ux) + 256'(uy) * 256'(uy) + 256'(soft_q) * 256'(soft_q);
    if (d2 == 0) d2 = 256'd1;
    uxd = (dx == 0) ? NUDGE_DX : ux;
    r   = floor_root(68'(uxd) * 68'(uxd) + 68'(uy) * 68'(uy));
    den = d2 * 256'(r);
    na  = (256'(grav_q) * 256'(d[207:176])) << FRAC;
    nb  = (256'(grav_q) * 256'(d[95:64])) << FRAC;
    sat = 1'b0;
    ax  = clip_quot(na * 256'(uxd), den, dx < 0, sat);
    bx  = clip_quot(nb * 256'(uxd), den, !(dx < 0), sat);
    ay  = '0;
    by  = '0;
    // a zero y difference leaves both y parts at zero
    if (dy != 0) begin
      ay = clip_quot(na * 256'(uy), den, dy < 0, sat);
      by = clip_quot(nb * 256'(uy), den, !(dy < 0), sat);
    end
    res.accel = {by, bx, ay, ax};
    res.sat   = sat;
    return res;
  endfunction

  assign pending_o = accel_fifo.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    accel_t exp_r;
    if (!rst_ni) begin
      grav_q       <= spga_pkg::GRAVITY_RST;
      soft_q       <= spga_pkg::SOFTENING_RST;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == spga_pkg::REG_GRAVITY) grav_q <= cfg_wdata_i;
        else soft_q <= cfg_wdata_i;
      end
      if (s_axis_tvalid && s_axis_tready) accel_fifo.push_back(predict_pair(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (accel_fifo.size() == 0) begin
          $display("%0t: result beat with nothing expected: %h %b", $time,
                   m_axis_tdata, m_axis_tuser);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = accel_fifo.pop_front();
          if (exp_r.accel !== m_axis_tdata || exp_r.sat !== m_axis_tuser[0]) begin
            $display("%0t: mismatch expected accel %h sat %b, actual accel %h sat %b",
                     $time, exp_r.accel, exp_r.sat, m_axis_tdata, m_axis_tuser[0]);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

`default_nettype wire

[tb/softened_pair_gravity_accel_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// softened_pair_gravity_accel_test
// Drives body pairs and register settings, stalls the result stream, and
// reports the checker's verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module softened_pair_gravity_accel_test;

  localparam int LATENCY   = 72;
  localparam int CYCLE_CAP = 400000;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [223:0] s_axis_tdata;   // pos_x_a, pos_y_a, mass_a, id_a, pos_x_b, pos_y_b, mass_b, id_b
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;   // accel_x_a, accel_y_a, accel_x_b, accel_y_b
  logic [0:0]   m_axis_tuser;   // saturated
  logic         cfg_we_i;
  logic [0:0]   cfg_idx_i;
  logic [31:0]  cfg_wdata_i;
  int           fail_count;
  int           pending;
  int           cycle_count;
  logic         sender_done;
  logic         long_hold;

  softened_pair_gravity_accel dut (.*);

  softened_pair_gravity_accel_checker checker_i (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit: ends the test whatever state it is in.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
        $display("softened_pair_gravity_accel test failed");
        $finish;
      end
    end
  end

  // Pick a coordinate: mostly nearby values, sometimes extremes or raw noise.
  function automatic logic [31:0] rand_pos(input logic [31:0] base);
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      2:       return base;
      default: return base + 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
    endcase
  endfunction

  function automatic logic [31:0] rand_mass();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return $urandom();
      2:       return 32'hFFFF_FFFF;
      default: return $urandom_range(0, 1 << 20);
    endcase
  endfunction

  function automatic logic [223:0] rand_pair();
    logic [31:0] xa, ya;
    logic [15:0] ia, ib;
    xa = $urandom_range(0, 3) == 0 ? $urandom()
                                   : 32'($signed($urandom_range(0, 1 << 23)) - (1 << 22));
    ya = $urandom_range(0, 3) == 0 ? $urandom()
                                   : 32'($signed($urandom_range(0, 1 << 23)) - (1 << 22));
    ia = $urandom();
    ib = $urandom_range(0, 15) == 0 ? ia : 16'($urandom());
    return {ib, rand_mass(), rand_pos(ya), rand_pos(xa), ia, rand_mass(), ya, xa};
  endfunction

  // Offer one beat after a random gap; hold until accepted.
  task automatic send_pair(input logic [223:0] d);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
    if (!sender_done && $urandom_range(0, 1)) gap = 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_reg(input spga_pkg::reg_idx_e idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // Let everything in flight drain before touching the registers.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  // Receiver: random stalls per beat, plus one long hold-off.
  initial begin
    int hold;
    m_axis_tready = 1'b0;
    long_hold     = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        long_hold = 1'b0;
      end
      hold = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 10);
      if (hold != 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin
    logic [31:0] grav_set[4];
    logic [31:0] soft_set[4];
    logic [31:0] big;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = spga_pkg::REG_GRAVITY;
    cfg_wdata_i   = '0;
    sender_done   = 1'b0;
    rst_ni        = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pairs at reset settings.
    big = 32'hFFFF_FFFF;
    send_pair({16'd7, 32'h0001_0000, 32'h0, 32'h0001_0000, 16'd7, 32'h0001_0000, 32'h0, 32'h0});
    // zero x difference
    send_pair({16'd2, 32'h0001_0000, 32'h0002_0000, 32'h0, 16'd1, 32'h0003_0000, 32'h0, 32'h0});
    // zero y difference
    send_pair({16'd2, 32'h0001_0000, 32'h0, 32'h0002_0000, 16'd1, 32'h0001_0000, 32'h0, 32'h0});
    // same place
    send_pair({16'd2, 32'h0001_0000, 32'h5, 32'h5, 16'd1, 32'h0001_0000, 32'h5, 32'h5});
    // massless bodies
    send_pair({16'd2, 32'h0, 32'h0001_0000, 32'hFFFF_0000, 16'd1, 32'h0, 32'h0, 32'h0});
    // extreme positions and masses, saturation
    send_pair({16'hFFFF, big, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0, big, 32'h8000_0000,
               32'h8000_0000});
    send_pair({16'h0, big, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, big, 32'h7FFF_FFFF,
               32'h8000_0000});
    send_pair({16'd9, big, 32'h1, 32'h1, 16'd8, big, 32'h0, 32'h0});
    send_pair({16'd9, 32'h10, 32'hFFFF_FFFF, 32'h1, 16'd8, 32'h10, 32'h0, 32'h0});
    drain();

    // Zero softening: coincident bodies use a unit distance squared.
    write_reg(spga_pkg::REG_SOFTENING, 32'h0);
    write_reg(spga_pkg::REG_GRAVITY, big);
    send_pair({16'd2, 32'h0001_0000, 32'h40, 32'h40, 16'd1, 32'h0001_0000, 32'h40, 32'h40});
    send_pair({16'd2, 32'h0001_0000, 32'h41, 32'h40, 16'd1, 32'h0001_0000, 32'h40, 32'h40});
    drain();

    // Random phases across a spread of settings, extremes included.
    grav_set = '{32'h0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0};
    soft_set = '{32'hFFFF_FFFF, 32'h0, 32'd19661, 32'h0};
    grav_set[3] = $urandom();
    soft_set[3] = $urandom_range(0, 1 << 20);
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(spga_pkg::REG_GRAVITY, grav_set[ph]);
      write_reg(spga_pkg::REG_SOFTENING, soft_set[ph]);
      for (int k = 0; k < 385; k++) begin
        if (ph == 2 && k == 100) long_hold = 1'b1;
        send_pair(rand_pair());
      end
      drain();
    end
    sender_done = 1'b1;

    if (fail_count == 0)
      $display("softened_pair_gravity_accel test passed");
    else
      $display("softened_pair_gravity_accel test failed");
    $finish;
  end
endmodule

`default_nettype wire

[sim.f]
+incdir+sv
sv/spga_pkg.sv
sv/spga_isqrt.sv
sv/spga_div.sv
sv/softened_pair_gravity_accel.sv
sv/spga_chk.sv
tb/softened_pair_gravity_accel_checker.sv
tb/softened_pair_gravity_accel_test.sv
